@@ design/fsd_pkg.sv @@
// shared types, constants and helpers of the error-diffusion dither block
`timescale 1ns / 1ps

package fsd_pkg;

  localparam int PIXEL_W        = 8;
  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 16;
  localparam int THRESHOLD_W    = 8;
  localparam int ERR_W          = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // register indexes of the config port
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD    = 2'd2;

  localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd480;
  localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RST    = 8'd128;

  localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

  // diffusion weights in sixteenths
  localparam int W_RIGHT       = 7;
  localparam int W_BELOW_LEFT  = 3;
  localparam int W_BELOW       = 5;
  localparam int W_BELOW_RIGHT = 1;
  localparam int WEIGHT_SHIFT  = 4;

  typedef logic signed [ERR_W-1:0] err_t;

  // quantizer decision and the error shares it produces
  typedef struct packed {
    logic bright;
    err_t left_final;   // finished value of the column to the left
    err_t here_value;   // partial value of the current column
    err_t right_share;  // carry to the next pixel
    err_t diag_share;   // share for the next column, next row
  } diffuse_t;

  function automatic err_t sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7fff;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[ERR_W-1:0];
    end
  endfunction

endpackage

@@ design/fsd_pixel_if.sv @@
// input pixel channel: valid/ready with one grey pixel per beat
`timescale 1ns / 1ps

interface fsd_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [fsd_pkg::PIXEL_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

@@ design/fsd_result_if.sv @@
// result channel: valid/ready with one dithered pixel and position flags per beat
`timescale 1ns / 1ps

interface fsd_result_if;
  logic                         valid;
  logic                         ready;
  logic [fsd_pkg::PIXEL_W-1:0]  pixel_out;
  logic                         end_of_line;
  logic                         end_of_frame;

  modport source (output valid, output pixel_out, output end_of_line, output end_of_frame,
                  input ready);
  modport sink (input valid, input pixel_out, input end_of_line, input end_of_frame,
                output ready);
endinterface

@@ design/fsd_line_store.sv @@
// line memory of next-row errors with a clearing sweep after reset
`timescale 1ns / 1ps

module fsd_line_store #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output fsd_pkg::err_t                rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  fsd_pkg::err_t                wr_data,
  output logic                         busy
);
  import fsd_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH);

  err_t              mem [MAX_WIDTH];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(MAX_WIDTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // read returns the old entry when the same address is written
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/fsd_quantizer.sv @@
// threshold decision and the four weighted error shares for one pixel
`timescale 1ns / 1ps

module fsd_quantizer #(
  parameter int FRAC_BITS = 4
) (
  input  logic [fsd_pkg::PIXEL_W-1:0]     pixel,
  input  logic [fsd_pkg::THRESHOLD_W-1:0] threshold,
  input  fsd_pkg::err_t                   right_carry,
  input  fsd_pkg::err_t                   below,
  input  fsd_pkg::err_t                   diag_pending,
  input  fsd_pkg::err_t                   left_partial,
  output fsd_pkg::diffuse_t               result
);
  import fsd_pkg::*;

  localparam int BASE_W = (FRAC_BITS + PIXEL_W > ERR_W) ? FRAC_BITS + PIXEL_W : ERR_W;
  localparam int SUM_W  = BASE_W + 3;
  localparam int SH_W   = SUM_W + 3;
  localparam logic signed [SUM_W-1:0] FULL_SCALE =
    SUM_W'(signed'({1'b0, PIXEL_MAX})) <<< FRAC_BITS;

  logic signed [SUM_W-1:0] pixel_fx;
  logic signed [SUM_W-1:0] thr_fx;
  logic signed [SUM_W-1:0] corrected;
  logic signed [SUM_W-1:0] err;
  logic signed [SH_W-1:0]  err_x;
  logic signed [SH_W-1:0]  share_r;
  logic signed [SH_W-1:0]  share_bl;
  logic signed [SH_W-1:0]  share_b;
  logic signed [SH_W-1:0]  share_br;
  logic                    bright;

  always_comb begin
    pixel_fx  = SUM_W'(signed'({1'b0, pixel})) <<< FRAC_BITS;
    thr_fx    = SUM_W'(signed'({1'b0, threshold})) <<< FRAC_BITS;
    corrected = pixel_fx + SUM_W'(right_carry) + SUM_W'(below);
    bright    = corrected > thr_fx;
    err       = bright ? corrected - FULL_SCALE : corrected;
    err_x     = SH_W'(err);

    // arithmetic shift gives the floor of each share
    share_r  = (err_x * SH_W'(W_RIGHT)) >>> WEIGHT_SHIFT;
    share_bl = (err_x * SH_W'(W_BELOW_LEFT)) >>> WEIGHT_SHIFT;
    share_b  = (err_x * SH_W'(W_BELOW)) >>> WEIGHT_SHIFT;
    share_br = (err_x * SH_W'(W_BELOW_RIGHT)) >>> WEIGHT_SHIFT;

    result.bright      = bright;
    result.left_final  = sat16(32'(left_partial) + 32'(share_bl));
    result.here_value  = sat16(32'(diag_pending) + 32'(share_b));
    result.right_share = sat16(32'(share_r));
    result.diag_share  = sat16(32'(share_br));
  end

endmodule

@@ design/floyd_steinberg_binary_dither_unit.sv @@
// top level of the floyd-steinberg binary dither: raster counters, pipeline and error state
// an accepted pixel waits in the input stage until the result register is free or drained
// throughput: one pixel per cycle while results.ready holds; the line memory takes one read and one write per pixel
//   on separate ports, and the input stage refills in the cycle the result register drains
// reset: synchronous; clears counters, carries and pipeline, loads register defaults,
//   then sweeps every entry of the line memory to zero with pixels.ready low
`timescale 1ns / 1ps

module floyd_steinberg_binary_dither_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int FRAC_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [fsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  fsd_pixel_if.sink                       pixels,
  fsd_result_if.source                    results
);
  import fsd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int LIM_W = ((CNT_W > IMAGE_WIDTH_W) ? CNT_W : IMAGE_WIDTH_W) + 1;

  // config registers
  logic [IMAGE_WIDTH_W-1:0]  image_width;
  logic [IMAGE_HEIGHT_W-1:0] image_height;
  logic [THRESHOLD_W-1:0]    threshold;

  // raster position of the next pixel to be accepted
  logic [COL_W-1:0]          col;
  logic [IMAGE_HEIGHT_W-1:0] row;

  // input stage
  logic                      a_valid;
  logic [PIXEL_W-1:0]        a_pixel;
  logic [COL_W-1:0]          a_col;
  logic                      a_last_col;
  logic                      a_last_row;
  logic                      a_row_nz;
  logic                      byp_hit;
  err_t                      byp_data;

  // result register
  logic                      o_valid;
  logic [PIXEL_W-1:0]        o_pixel;
  logic                      o_eol;
  logic                      o_eof;

  // error state: horizontal carries and the one column not yet written back
  err_t                      right_carry;
  err_t                      diag_pending;
  logic                      pend_valid;
  logic [COL_W-1:0]          pend_addr;
  err_t                      pend_data;

  logic                      store_busy;
  err_t                      rd_data;
  logic                      accept;
  logic                      a_advance;
  logic [LIM_W-1:0]          eff_width;
  logic [IMAGE_HEIGHT_W-1:0] eff_height;
  logic                      last_col;
  logic                      last_row;
  err_t                      below;
  diffuse_t                  dq;
  logic                      wr_en;
  err_t                      wr_data;

  // ---------------------------------------------------------------------------
  // config port, writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      threshold    <= THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[IMAGE_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[IMAGE_HEIGHT_W-1:0];
        CFG_THRESHOLD:    threshold    <= cfg_data[THRESHOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: input stage moves on whenever the result register is free or drained
  assign a_advance    = a_valid && (!o_valid || results.ready);
  assign pixels.ready = !store_busy && (!a_valid || a_advance);
  assign accept       = pixels.valid && pixels.ready;

  assign results.valid        = o_valid;
  assign results.pixel_out    = o_pixel;
  assign results.end_of_line  = o_eol;
  assign results.end_of_frame = o_eof;

  // ---------------------------------------------------------------------------
  // row and frame boundaries, width clamped to [1, MAX_WIDTH], zero height is one row
  always_comb begin
    if (image_width == '0) begin
      eff_width = LIM_W'(1);
    end else if (LIM_W'(image_width) > LIM_W'(MAX_WIDTH)) begin
      eff_width = LIM_W'(MAX_WIDTH);
    end else begin
      eff_width = LIM_W'(image_width);
    end
    eff_height = (image_height == '0) ? IMAGE_HEIGHT_W'(1) : image_height;
    last_col   = (LIM_W'(col) + LIM_W'(1)) >= eff_width;
    last_row   = ({1'b0, row} + 17'd1) >= {1'b0, eff_height};
  end

  // ---------------------------------------------------------------------------
  // error from the row above: the pending column is newest, then a write that
  // landed in the same cycle as the memory read, then the memory itself
  always_comb begin
    if (!a_row_nz) begin
      below = '0;
    end else if (pend_valid && pend_addr == a_col) begin
      below = pend_data;
    end else if (byp_hit) begin
      below = byp_data;
    end else begin
      below = rd_data;
    end
  end

  fsd_quantizer #(
    .FRAC_BITS (FRAC_BITS)
  ) u_quant (
    .pixel        (a_pixel),
    .threshold    (threshold),
    .right_carry  (right_carry),
    .below        (below),
    .diag_pending (diag_pending),
    .left_partial (pend_data),
    .result       (dq)
  );

  // pending column is written back when the next pixel is done; the lower-left
  // share completes it unless the new pixel starts a row
  assign wr_en   = a_advance && pend_valid;
  assign wr_data = (a_col != '0) ? dq.left_final : pend_data;

  fsd_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pend_addr),
    .wr_data (wr_data),
    .busy    (store_busy)
  );

  // ---------------------------------------------------------------------------
  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      row          <= '0;
      a_valid      <= 1'b0;
      o_valid      <= 1'b0;
      pend_valid   <= 1'b0;
      right_carry  <= '0;
      diag_pending <= '0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + IMAGE_HEIGHT_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end else if (a_advance) begin
        a_valid <= 1'b0;
      end

      if (a_advance) begin
        o_valid    <= 1'b1;
        pend_valid <= 1'b1;
        // carries stop at the end of a row
        right_carry  <= a_last_col ? '0 : dq.right_share;
        diag_pending <= a_last_col ? '0 : dq.diag_share;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_pixel    <= pixels.pixel_in;
      a_col      <= col;
      a_last_col <= last_col;
      a_last_row <= last_row;
      a_row_nz   <= row != '0;
      // catch a write-back to the address being read in this same cycle
      byp_hit    <= wr_en && (pend_addr == col);
      byp_data   <= wr_data;
    end
    if (a_advance) begin
      pend_addr <= a_col;
      pend_data <= dq.here_value;
      o_pixel   <= dq.bright ? PIXEL_MAX : '0;
      o_eol     <= a_last_col;
      o_eof     <= a_last_col && a_last_row;
    end
  end

endmodule

@@ tb/sv/floyd_steinberg_binary_dither_unit_tb.sv @@
// self-checking testbench of the binary error-diffusion dither unit with a scoreboard class
`timescale 1ns / 1ps

module floyd_steinberg_binary_dither_unit_tb;
  import fsd_pkg::*;

  localparam int MAX_W = 1024;
  localparam int FRAC = 4;
  localparam int RANDOM_ITEMS = 1400;
  // reset sweep of the line memory plus the longest random stall, several times over
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;
  // config index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  // pixel content styles of one random phase
  typedef enum int {PAT_ANY, PAT_EXTREME, PAT_NEAR_THR, PAT_FLAT} pattern_e;

  typedef struct {
    logic [PIXEL_W-1:0] level;
    logic               eol;
    logic               eof;
  } dot_t;

  // error-diffusion predictor plus the queue of dots it still owes
  class halftone_scoreboard;
    err_t                      row_err [MAX_W];
    err_t                      carry_right;
    err_t                      carry_diag;
    int unsigned               col;
    int unsigned               row;
    logic [IMAGE_WIDTH_W-1:0]  width_reg;
    logic [IMAGE_HEIGHT_W-1:0] height_reg;
    logic [THRESHOLD_W-1:0]    thr_reg;
    dot_t                      pending_dots [$];
    int                        mismatches;
    int                        n_dots;
    int                        n_lines;
    int                        n_frames;
    int                        n_bright;

    function new();
      foreach (row_err[i]) row_err[i] = '0;
      carry_right = '0;
      carry_diag = '0;
      col = 0;
      row = 0;
      width_reg = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      thr_reg = THRESHOLD_RST;
      mismatches = 0;
      n_dots = 0;
      n_lines = 0;
      n_frames = 0;
      n_bright = 0;
    endfunction

    function err_t clip16(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return err_t'(v);
    endfunction

    // floor(v * wgt / 16)
    function int portion(int v, int wgt);
      int p;
      p = v * wgt;
      return p >>> WEIGHT_SHIFT;
    endfunction

    function void mirror_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg = data[IMAGE_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = data[IMAGE_HEIGHT_W-1:0];
        CFG_THRESHOLD:    thr_reg = data[THRESHOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_pixel(logic [PIXEL_W-1:0] level);
      int unsigned w;
      int unsigned h;
      bit          last_col;
      bit          last_row;
      bit          bright;
      int          below;
      int          corrected;
      int          err;
      dot_t        d;
      w = 32'(width_reg);
      if (w < 1) w = 1;
      else if (w > MAX_W) w = MAX_W;
      h = 32'(height_reg);
      if (h < 1) h = 1;
      last_col = (col + 1 >= w);
      last_row = (row + 1 >= h);
      below = (row != 0) ? int'(row_err[col]) : 0;
      corrected = (int'(level) << FRAC) + int'(carry_right) + below;
      bright = (corrected > (int'(thr_reg) << FRAC));
      err = corrected - (bright ? (int'(PIXEL_MAX) << FRAC) : 0);
      if (col > 0) row_err[col-1] = clip16(int'(row_err[col-1]) + portion(err, W_BELOW_LEFT));
      row_err[col] = clip16(int'(carry_diag) + portion(err, W_BELOW));
      if (last_col) begin
        carry_right = '0;
        carry_diag = '0;
      end else begin
        carry_right = clip16(portion(err, W_RIGHT));
        carry_diag = clip16(portion(err, W_BELOW_RIGHT));
      end
      d.level = bright ? PIXEL_MAX : '0;
      d.eol = last_col;
      d.eof = last_col && last_row;
      pending_dots.push_back(d);
      if (last_col) begin
        col = 0;
        row = last_row ? 0 : ((row + 1) & 32'hFFFF);
      end else begin
        col = (col + 1) & 32'h3FF;
      end
    endfunction

    function void check_dot(logic [PIXEL_W-1:0] level, logic eol, logic eof);
      dot_t want;
      n_dots++;
      if (pending_dots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat %0d with nothing expected: out=%0d eol=%b eof=%b",
                   $realtime, n_dots, level, eol, eof);
        return;
      end
      want = pending_dots.pop_front();
      if (level !== want.level || eol !== want.eol || eof !== want.eof) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat %0d expected out=%0d eol=%b eof=%b, got out=%0d eol=%b eof=%b",
                   $realtime, n_dots, want.level, want.eol, want.eof, level, eol, eof);
      end
      if (want.eol) n_lines++;
      if (want.eof) n_frames++;
      if (want.level == PIXEL_MAX) n_bright++;
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fsd_pixel_if  pix_ch ();
  fsd_result_if res_ch ();

  halftone_scoreboard sb;

  // calm phases drop every gap and stall on both sides
  bit calm;
  int random_sent;
  int settings_used;

  floyd_steinberg_binary_dither_unit #(
    .MAX_WIDTH(MAX_W),
    .FRAC_BITS(FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixels   (pix_ch),
    .results  (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_value(pattern_e pattern, int unsigned thr);
    int v;
    case (pattern)
      PAT_EXTREME: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
      // hovering around the decision level stresses the strict compare
      PAT_NEAR_THR: v = int'(thr) + int'($urandom_range(0, 6)) - 3;
      // flat grey gives a steady dither pattern with long error chains
      PAT_FLAT: v = ($urandom_range(0, 9) < 7) ? 85 : int'($urandom_range(0, 255));
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIXEL_W-1:0];
  endfunction

  // one pixel beat; valid stays high when the next beat follows with no gap
  task automatic send_pixel(input logic [PIXEL_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel_in <= value;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    sb.take_pixel(value);
  endtask

  task automatic park_input();
    pix_ch.valid <= 1'b0;
  endtask

  // every result maps to one pixel, so an empty queue means the pipe is empty
  task automatic wait_drained();
    while (sb.pending_dots.size() != 0) @(posedge clk);
  endtask

  // leaves the write enable high; set_config lowers it once at the end
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.mirror_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [IMAGE_WIDTH_W-1:0] w,
                            input logic [IMAGE_HEIGHT_W-1:0] h,
                            input logic [THRESHOLD_W-1:0] thr,
                            input bit poke_spare);
    logic [CFG_DATA_W-1:0] junk;
    wait_drained();
    // unused upper data bits get random junk half of the time
    junk = ($urandom_range(0, 1) == 1) ? CFG_DATA_W'($urandom) : '0;
    write_reg(CFG_IMAGE_WIDTH, {junk[CFG_DATA_W-1:IMAGE_WIDTH_W], w});
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_THRESHOLD, {junk[CFG_DATA_W-1:THRESHOLD_W], thr});
    if (poke_spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic random_phase(input bit big);
    int unsigned w;
    int unsigned h;
    int unsigned thr;
    int unsigned weff;
    int unsigned heff;
    int unsigned count;
    int unsigned r;
    pattern_e    pattern;
    r = $urandom_range(0, 99);
    if (big) w = ($urandom_range(0, 1) == 1) ? MAX_W : $urandom_range(MAX_W + 1, 2047);
    else if (r < 4) w = $urandom_range(0, 1);
    else if (r < 70) w = $urandom_range(2, 12);
    else if (r < 95) w = $urandom_range(13, 64);
    else w = $urandom_range(MAX_W + 1, 2047);
    r = $urandom_range(0, 99);
    if (big) h = 2;
    else if (r < 5) h = 0;
    else if (r < 80) h = $urandom_range(1, 5);
    else if (r < 90) h = $urandom_range(6, 20);
    else h = $urandom_range(21, 65535);
    r = $urandom_range(0, 99);
    thr = (r < 10) ? 0 : (r < 20) ? 255 : $urandom_range(0, 255);
    weff = (w < 1) ? 1 : (w > MAX_W) ? MAX_W : w;
    heff = (h < 1) ? 1 : h;
    // whole frames most of the time, cut-off runs leave the counters mid-frame
    if (big) count = MAX_W + $urandom_range(1, 8);
    else if ($urandom_range(0, 9) < 6 && weff * heff <= 120) count = weff * heff;
    else count = $urandom_range(1, (weff * 2 > 40) ? 40 : weff * 2);
    pattern = pattern_e'($urandom_range(0, 3));
    set_config(IMAGE_WIDTH_W'(w), IMAGE_HEIGHT_W'(h), THRESHOLD_W'(thr),
               $urandom_range(0, 9) == 0);
    calm = ($urandom_range(0, 3) == 0);
    repeat (count) send_pixel(pick_value(pattern, thr));
    park_input();
    random_sent += count;
  endtask

  // result side: random stalls, one check per accepted beat
  initial begin
    int hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        sb.check_dot(res_ch.pixel_out, res_ch.end_of_line, res_ch.end_of_frame);
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else begin
        res_ch.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // watchdog: ends the run when no beat moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat for %0d cycles, %0d dots still owed",
             STALL_LIMIT, sb.pending_dots.size());
    $display("[floyd_steinberg_binary_dither_unit] ERROR");
    $finish;
  end

  initial begin
    bit big_done;
    bit do_big;
    sb = new();
    calm = 1'b0;
    random_sent = 0;
    settings_used = 0;
    big_done = 1'b0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel_in <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register defaults straight out of reset; ready stays low during the memory sweep
    send_pixel(8'd128);
    send_pixel(8'd129);
    send_pixel(8'd0);
    park_input();

    // two-by-two frame, threshold at mid scale; the default-width row ends here
    set_config(2, 2, 128, 1'b0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd128);
    send_pixel(8'd129);
    park_input();

    // zero width and zero height fall back to one pixel per frame, threshold at zero
    set_config(0, 0, 0, 1'b1);
    send_pixel(8'd0);
    send_pixel(8'd255);
    park_input();

    // single column over three rows, threshold at full scale
    set_config(1, 3, 255, 1'b0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd255);
    park_input();

    // stop mid-row so the column counter sits past the next width
    set_config(5, 3, 128, 1'b0);
    send_pixel(8'd200);
    send_pixel(8'd60);
    send_pixel(8'd255);
    send_pixel(8'd0);
    park_input();

    // shrunk width: the stale column ends the row at once
    set_config(2, 2, 100, 1'b0);
    send_pixel(8'd10);
    send_pixel(8'd250);
    send_pixel(8'd90);
    send_pixel(8'd170);
    park_input();

    // get into the second row, then shrink the height below it
    set_config(3, 4, 128, 1'b0);
    send_pixel(8'd77);
    send_pixel(8'd77);
    send_pixel(8'd77);
    send_pixel(8'd77);
    park_input();
    set_config(3, 1, 128, 1'b0);
    send_pixel(8'd33);
    send_pixel(8'd99);
    park_input();

    // random phases, one of them a full-width row to reach the last column of the store
    while (random_sent < RANDOM_ITEMS) begin
      do_big = !big_done && (random_sent >= 300 || $urandom_range(0, 19) == 0);
      random_phase(do_big);
      if (do_big) big_done = 1'b1;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d pixel beats under %0d register settings: %0d rows and %0d frames closed",
             sb.n_dots, settings_used, sb.n_lines, sb.n_frames);
    $display("%0d white dots, %0d mismatches", sb.n_bright, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_dots.size() == 0) begin
      $display("[floyd_steinberg_binary_dither_unit] OK");
    end else begin
      $display("[floyd_steinberg_binary_dither_unit] ERROR");
    end
    $finish;
  end

endmodule
